/* hdl/phase_accumulator_cosine_generator_core_macros.svh */
// Assertion helpers shared by the core
`ifndef PHASE_ACCUMULATOR_COSINE_GENERATOR_CORE_MACROS_SVH
`define PHASE_ACCUMULATOR_COSINE_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, clocked on clock, off during reset
`define PACG_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pacg: same-cycle check failed");

// next-cycle implication
`define PACG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pacg: next-cycle check failed");

`endif

/* hdl/pacg_pkg.sv */
package pacg_pkg;

   // phase is carried between front and back left-aligned in 48 bits
   localparam int PH48_W = 48;

   localparam int TAB_DEPTH = 16;
   localparam int TAB_IDX_W = $clog2(TAB_DEPTH);
   localparam int MAG_W = 15;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // shared multiplier operand widths
   localparam int MUL_A_W = 31;
   localparam int MUL_B_W = 19;
   localparam int PROD_W = MUL_A_W + MUL_B_W;

   localparam logic [MUL_B_W-1:0] TWO_PI_Q16 = 19'd411775;
   localparam logic [MUL_B_W-1:0] INV24_Q16 = 19'd2731;

   localparam logic METHOD_TABLE = 1'b0;
   localparam logic METHOD_TAYLOR = 1'b1;

   typedef struct packed {
      logic method;
      logic [PH48_W-1:0] ph48;
   } pacg_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } pacg_qstat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULX,
      ST_SQX,
      ST_SQT2,
      ST_INV24,
      ST_FIN
   } pacg_state_type;

   // cos(i*pi/32) in Q1.15, first entry saturated
   function automatic logic [MAG_W-1:0] pacg_quarter(input logic [TAB_IDX_W-1:0] idx);
      logic [MAG_W-1:0] v;
      case (idx)
         4'd0: v = 15'd32767;
         4'd1: v = 15'd32610;
         4'd2: v = 15'd32138;
         4'd3: v = 15'd31357;
         4'd4: v = 15'd30274;
         4'd5: v = 15'd28899;
         4'd6: v = 15'd27246;
         4'd7: v = 15'd25330;
         4'd8: v = 15'd23170;
         4'd9: v = 15'd20788;
         4'd10: v = 15'd18205;
         4'd11: v = 15'd15447;
         4'd12: v = 15'd12540;
         4'd13: v = 15'd9512;
         4'd14: v = 15'd6393;
         4'd15: v = 15'd3212;
         default: v = 15'd0;
      endcase
      return v;
   endfunction

endpackage

/* hdl/pacg_front.sv */
module pacg_front #(
   parameter int PHASE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [31:0]            req_phase_step,
   input  logic                   csr_wr,
   input  logic                   csr_method,
   input  pacg_pkg::pacg_qstat_type qstat,
   output logic                   push,
   output pacg_pkg::pacg_item_type item
);

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic                  method_ff, method_in;

   assign push = req_valid && !qstat.full;

   // size cast drops or zero-fills the step to the accumulator width
   always_comb begin
      phase_in = phase_ff;
      if (push) begin
         phase_in = phase_ff + PHASE_BITS'(req_phase_step);
      end
   end

   assign method_in = csr_wr ? csr_method : method_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         method_ff <= pacg_pkg::METHOD_TABLE;
      end else begin
         phase_ff <= phase_in;
         method_ff <= method_in;
      end
   end

   always_comb begin
      item.method = method_ff;
      item.ph48 = pacg_pkg::PH48_W'(phase_in) << (pacg_pkg::PH48_W - PHASE_BITS);
   end

endmodule

/* hdl/pacg_queue.sv */
module pacg_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pacg_pkg::pacg_item_type push_item,
   input  logic                    pop,
   output pacg_pkg::pacg_item_type head,
   output pacg_pkg::pacg_qstat_type qstat
);

   pacg_pkg::pacg_item_type            ent_ff [pacg_pkg::Q_DEPTH];
   logic [pacg_pkg::Q_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [pacg_pkg::Q_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [pacg_pkg::Q_CNT_W-1:0]       cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head = ent_ff[rd_ptr_ff];
   assign qstat.full = (cnt_ff == pacg_pkg::Q_CNT_W'(pacg_pkg::Q_DEPTH));
   assign qstat.empty = (cnt_ff == '0);

endmodule

/* hdl/pacg_back.sv */
module pacg_back (
   input  logic                     clock,
   input  logic                     reset,
   input  pacg_pkg::pacg_qstat_type qstat,
   input  pacg_pkg::pacg_item_type  head,
   output logic                     pop,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic signed [15:0]       rsp_sample
);

   pacg_pkg::pacg_state_type state_ff, state_in;

   logic [pacg_pkg::MUL_A_W-1:0] tsh_ff;
   logic                         neg_ff;
   logic [pacg_pkg::PROD_W-1:0]  prod_ff;
   logic [17:0]                  t2_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]           sample_ff;

   logic                         out_free;
   logic                         out_load;
   logic signed [15:0]           out_val;
   logic                         tay_load;
   logic                         t2_load;
   logic [pacg_pkg::MUL_A_W-1:0] mul_a;
   logic [pacg_pkg::MUL_B_W-1:0] mul_b;

   // head decode: fold into first quadrant and table lookup
   logic [1:0]                     quad;
   logic [46:0]                    low, t48;
   logic [pacg_pkg::MUL_A_W-1:0]   tsh_new;
   logic                           tay_neg;
   logic [pacg_pkg::TAB_IDX_W-1:0] r, tidx;
   logic [pacg_pkg::MAG_W-1:0]     tmag;
   logic signed [15:0]             tab_val;

   // back-end arithmetic
   logic [pacg_pkg::PROD_W-1:0] rnd32, rnd16;
   logic [16:0]                 x;
   logic [17:0]                 t2;
   logic [18:0]                 t4;
   logic [14:0]                 term;
   logic [18:0]                 half_t2;
   logic signed [18:0]          c;
   logic [17:0]                 cu;
   logic [18:0]                 cinc;
   logic [17:0]                 s;
   logic [pacg_pkg::MAG_W-1:0]  smag;
   logic signed [15:0]          tay_val;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      quad = head.ph48[47:46];
      low = head.ph48[46:0];
      // odd quadrants measure back from the next axis
      t48 = quad[0] ? 47'd0 - low : low;
      tsh_new = t48[46:16];
      tay_neg = quad[1] ^ quad[0];
      r = head.ph48[45 -: pacg_pkg::TAB_IDX_W];
      tidx = quad[0] ? pacg_pkg::TAB_IDX_W'(pacg_pkg::TAB_DEPTH - 1) - r : r;
      tmag = pacg_pkg::pacg_quarter(tidx);
      tab_val = tay_neg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
   end

   always_comb begin
      rnd32 = prod_ff + (pacg_pkg::PROD_W'(1) << 31);
      rnd16 = prod_ff + (pacg_pkg::PROD_W'(1) << 15);
      x = rnd32[48:32];
      t2 = rnd16[33:16];
      t4 = rnd16[34:16];
      term = rnd16[30:16];
      half_t2 = (19'(t2_ff) + 19'd1) >> 1;
      c = 19'sd65536 - $signed(half_t2) + $signed({4'd0, term});
      cu = c[18] ? 18'd0 : c[17:0];
      cinc = 19'(cu) + 19'd1;
      s = cinc[18:1];
      smag = (s > 18'd32767) ? 15'h7fff : s[14:0];
      tay_val = neg_ff ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pacg_pkg::ST_IDLE: begin
            if (!qstat.empty && head.method == pacg_pkg::METHOD_TAYLOR) begin
               state_in = pacg_pkg::ST_MULX;
            end
         end
         pacg_pkg::ST_MULX: state_in = pacg_pkg::ST_SQX;
         pacg_pkg::ST_SQX: state_in = pacg_pkg::ST_SQT2;
         pacg_pkg::ST_SQT2: state_in = pacg_pkg::ST_INV24;
         pacg_pkg::ST_INV24: state_in = pacg_pkg::ST_FIN;
         pacg_pkg::ST_FIN: begin
            if (out_free) begin
               state_in = pacg_pkg::ST_IDLE;
            end
         end
         default: state_in = pacg_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop = 1'b0;
      out_load = 1'b0;
      out_val = tab_val;
      tay_load = 1'b0;
      t2_load = 1'b0;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         pacg_pkg::ST_IDLE: begin
            if (!qstat.empty) begin
               if (head.method == pacg_pkg::METHOD_TAYLOR) begin
                  pop = 1'b1;
                  tay_load = 1'b1;
               end else if (out_free) begin
                  pop = 1'b1;
                  out_load = 1'b1;
               end
            end
         end
         pacg_pkg::ST_MULX: begin
            mul_a = tsh_ff;
            mul_b = pacg_pkg::TWO_PI_Q16;
         end
         pacg_pkg::ST_SQX: begin
            mul_a = pacg_pkg::MUL_A_W'(x);
            mul_b = pacg_pkg::MUL_B_W'(x);
         end
         pacg_pkg::ST_SQT2: begin
            t2_load = 1'b1;
            mul_a = pacg_pkg::MUL_A_W'(t2);
            mul_b = pacg_pkg::MUL_B_W'(t2);
         end
         pacg_pkg::ST_INV24: begin
            mul_a = pacg_pkg::MUL_A_W'(t4);
            mul_b = pacg_pkg::INV24_Q16;
         end
         pacg_pkg::ST_FIN: begin
            out_val = tay_val;
            out_load = out_free;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pacg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      // the t^4/24 product is still needed while a finished sample waits
      if (state_ff != pacg_pkg::ST_FIN) begin
         prod_ff <= mul_a * mul_b;
      end
      if (tay_load) begin
         tsh_ff <= tsh_new;
         neg_ff <= tay_neg;
      end
      if (t2_load) begin
         t2_ff <= t2;
      end
      if (out_load) begin
         sample_ff <= out_val;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample = sample_ff;

endmodule

/* hdl/phase_accumulator_cosine_generator_core.sv */
// Cosine NCO. Each accepted item adds req_phase_step to a PHASE_BITS-wide phase
// accumulator (a full turn is 2^PHASE_BITS) and returns cos(phase) in Q1.15,
// limited to +-32767. csr_method 0 selects a 16-entry quarter-wave table with
// quadrant mirroring, 1 a three-term Taylor series evaluated in Q2.16; write it
// only while the block is idle. The front end updates the phase in the cycle
// an item is taken and hands it through a two-entry queue to the back end.
// A table item is looked up and registered straight from ST_IDLE, so table samples
// stream at one per clock while the output is not stalled. A Taylor item passes
// through ST_MULX, ST_SQX, ST_SQT2, ST_INV24 and ST_FIN: one shared 31x19 multiplier forms
// the radian scaling, t^2, t^4 and the t^4/24 product one after another, then
// the sum is rounded and clamped in ST_FIN. csr_ready is always high.
`include "phase_accumulator_cosine_generator_core_macros.svh"

module phase_accumulator_cosine_generator_core #(
   parameter int PHASE_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_phase_step,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_method
);

   pacg_pkg::pacg_item_type  push_item, head;
   pacg_pkg::pacg_qstat_type qstat;
   logic                     push, pop;

   assign csr_ready = 1'b1;
   assign req_stall = qstat.full;

   pacg_front #(
      .PHASE_BITS(PHASE_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_phase_step(req_phase_step),
      .csr_wr(csr_valid && csr_ready),
      .csr_method(csr_method),
      .qstat(qstat),
      .push(push),
      .item(push_item)
   );

   pacg_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_item(push_item),
      .pop(pop),
      .head(head),
      .qstat(qstat)
   );

   pacg_back u_back (
      .clock(clock),
      .reset(reset),
      .qstat(qstat),
      .head(head),
      .pop(pop),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_sample(rsp_sample)
   );

   `PACG_ASSERT_NOW(a_queue_state, 1'b1, !(qstat.full && qstat.empty))
   `PACG_ASSERT_NEXT(a_push_lands, req_valid && !req_stall, !qstat.empty)
   `PACG_ASSERT_NOW(a_pop_has_item, pop, !qstat.empty)
   `PACG_ASSERT_NOW(a_sample_range, rsp_valid, rsp_sample != 16'sh8000)

endmodule
